/* rtl/hrm_pkg.sv */
package hrm_pkg;

	// Default depth of the run buffer.
	localparam int DEF_MAX_RUN = 32;

	// No more than this many result items come from one input item.
	localparam int RESULT_CAP = 34;

	// Width of a result count within one input item.
	localparam int CNT_W = $clog2(RESULT_CAP + 1);

	// Depth of the queue between front and back; a power of two is not required.
	localparam int Q_DEPTH = 4;

	// What closes a run: nothing, the text <num>, or the buffered bytes.
	typedef enum logic [1:0] {
		CLOSE_NONE,
		CLOSE_NUM,
		CLOSE_BUF
	} close_t;

	// Output work caused by one input item: an optional close part, then up to two literal
	// bytes. The last flag marks the final byte of the string.
	typedef struct packed {
		close_t             close;
		logic [CNT_W-1:0]   cnt;
		logic               close_ovf;
		logic               b0_v;
		logic [7:0]         b0;
		logic               b0_ovf;
		logic               b1_v;
		logic [7:0]         b1;
		logic               b1_ovf;
		logic               last;
	} rec_t;

endpackage

/* rtl/hex_run_masker.sv */
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   in_byte[7:0], in_last
// result    out        out_valid/out_stall out_byte[7:0], out_last, overflow
// config    in         cfg_valid/cfg_ready min_digits[15:0]
//
// The front takes one item per cycle unless stalled and turns it into one queued record
// of output work. The back drains records at one result byte per cycle while the output
// does not stall; one item causes 1 to 34 bytes, which leave through the back's pipeline
// registers. Input stalls while the queue is full, or when an item would write the
// run buffer while a queued or running flush still reads it from the buffer memory.
// Reset is asynchronous and clears all control state; the run buffer is not cleared.

module hex_run_masker #(
	parameter int MAX_RUN = hrm_pkg::DEF_MAX_RUN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] min_digits,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        overflow
);

	import hrm_pkg::*;

	localparam int AW = $clog2(MAX_RUN);

	// Records of output work pass from front to back through the queue.
	rec_t          push_rec;
	rec_t          head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          head_valid;

	// The run buffer is written by the front and read back by the back when a run is
	// flushed; buf_done tells the front that a flush no longer needs the buffer.
	logic          buf_done;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	hrm_front #(
		.MAX_RUN (MAX_RUN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.min_digits (min_digits),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.q_full     (q_full),
		.push       (push),
		.push_rec   (push_rec),
		.buf_done   (buf_done),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	hrm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	hrm_ram #(
		.WIDTH (8),
		.DEPTH (MAX_RUN)
	) u_run_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	hrm_back #(
		.MAX_RUN (MAX_RUN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.buf_done   (buf_done),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.overflow   (overflow)
	);

endmodule

/* rtl/hrm_ram.sv */
module hrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read data holds its value while no read is requested.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/hrm_front.sv */
module hrm_front #(
	parameter int MAX_RUN = hrm_pkg::DEF_MAX_RUN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [15:0]                min_digits,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 in_byte,
	input  logic                       in_last,
	input  logic                       q_full,
	output logic                       push,
	output hrm_pkg::rec_t              push_rec,
	input  logic                       buf_done,
	output logic                       ram_we,
	output logic [$clog2(MAX_RUN)-1:0] ram_waddr,
	output logic [7:0]                 ram_wdata
);

	import hrm_pkg::*;

	localparam int AW = $clog2(MAX_RUN);
	localparam int BW = $clog2(Q_DEPTH + 2);
	localparam logic [CNT_W-1:0] OVF_CNT =
		CNT_W'((MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP);

	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";
	localparam logic [7:0] CH_LA   = "a";
	localparam logic [7:0] CH_LF   = "f";
	localparam logic [7:0] CH_LX   = "x";
	localparam logic [7:0] CH_LZ   = "z";
	localparam logic [7:0] CH_UA   = "A";
	localparam logic [7:0] CH_UF   = "F";
	localparam logic [7:0] CH_UX   = "X";
	localparam logic [7:0] CH_UZ   = "Z";

	typedef enum logic [1:0] {
		MODE_TOP,
		MODE_ZERO,
		MODE_RUN,
		MODE_RAW
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic        first;
		logic        zwf;
		logic [15:0] len;
		logic        digit;
	} scan_t;

	typedef struct packed {
		scan_t          s;
		rec_t           r;
		logic           we;
		logic [AW-1:0]  wa;
		logic [7:0]     wd;
	} ctx_t;

	scan_t          scan_q;
	logic [15:0]    min_digits_q;
	logic [BW-1:0]  busy_q;
	ctx_t           nxt;
	logic           accept;
	logic           buf_inc;

	function automatic logic is_dec(logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_hex(logic [7:0] b);
		return is_dec(b) || ((b >= CH_LA) && (b <= CH_LF)) || ((b >= CH_UA) && (b <= CH_UF));
	endfunction

	function automatic logic is_alnum(logic [7:0] b);
		return is_dec(b) || ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
	endfunction

	function automatic ctx_t emit(ctx_t ci, logic [7:0] b, logic ovf);
		ctx_t c;
		c = ci;
		if (!c.r.b0_v) begin
			c.r.b0_v   = 1'b1;
			c.r.b0     = b;
			c.r.b0_ovf = ovf;
		end else begin
			c.r.b1_v   = 1'b1;
			c.r.b1     = b;
			c.r.b1_ovf = ovf;
		end
		return c;
	endfunction

	function automatic ctx_t start_run(ctx_t ci);
		ctx_t c;
		c = ci;
		c.s.mode  = MODE_RUN;
		c.s.len   = '0;
		c.s.digit = 1'b0;
		return c;
	endfunction

	function automatic logic decided(scan_t s, logic [15:0] md);
		return s.digit && (s.len >= md);
	endfunction

	function automatic ctx_t close_run(ctx_t ci, logic [15:0] md);
		ctx_t c;
		c = ci;
		if (c.s.mode == MODE_RUN) begin
			if (decided(c.s, md)) begin
				c.r.close     = CLOSE_NUM;
				c.r.close_ovf = 1'b0;
			end else if (c.s.len != '0) begin
				c.r.close     = CLOSE_BUF;
				c.r.close_ovf = 1'b0;
				c.r.cnt       = (c.s.len > 16'(RESULT_CAP)) ? CNT_W'(RESULT_CAP)
				                                            : c.s.len[CNT_W-1:0];
			end
		end
		c.s.mode  = MODE_TOP;
		c.s.len   = '0;
		c.s.digit = 1'b0;
		return c;
	endfunction

	// A hex digit inside a run. The store flag is low for a held '0' that is already in
	// entry zero of the buffer.
	function automatic ctx_t run_byte(ctx_t ci, logic [7:0] b, logic store, logic [15:0] md);
		ctx_t        c;
		logic [15:0] idx;
		c   = ci;
		idx = '0;
		if (c.s.mode == MODE_RAW) begin
			c = emit(c, b, 1'b1);
		end else begin
			if (is_dec(b)) begin
				c.s.digit = 1'b1;
			end
			if (c.s.len != 16'hFFFF) begin
				c.s.len = c.s.len + 16'd1;
			end
			if (!decided(c.s, md)) begin
				if (c.s.len <= 16'(MAX_RUN)) begin
					if (store) begin
						idx  = c.s.len - 16'd1;
						c.we = 1'b1;
						c.wa = idx[AW-1:0];
						c.wd = b;
					end
				end else begin
					c.r.close     = CLOSE_BUF;
					c.r.cnt       = OVF_CNT;
					c.r.close_ovf = 1'b1;
					c             = emit(c, b, 1'b1);
					c.s.mode      = MODE_RAW;
				end
			end
		end
		return c;
	endfunction

	function automatic ctx_t top_byte(ctx_t ci, logic [7:0] b, logic [15:0] md);
		ctx_t c;
		logic first;
		c       = ci;
		first   = c.s.first;
		c.s.first = 1'b0;
		if (b == CH_ZERO) begin
			c.s.mode = MODE_ZERO;
			c.s.zwf  = first;
			// A leading '0' may open a run, so it goes into entry zero now.
			if (first) begin
				c.we = 1'b1;
				c.wa = '0;
				c.wd = CH_ZERO;
			end
		end else if (!is_alnum(b)) begin
			c = emit(c, b, 1'b0);
			c = start_run(c);
		end else if (first && is_hex(b)) begin
			c = start_run(c);
			c = run_byte(c, b, 1'b1, md);
		end else begin
			c = emit(c, b, 1'b0);
		end
		return c;
	endfunction

	function automatic ctx_t in_run_byte(ctx_t ci, logic [7:0] b, logic [15:0] md);
		ctx_t c;
		c = ci;
		if (is_hex(b)) begin
			c = run_byte(c, b, 1'b1, md);
		end else begin
			c = close_run(c, md);
			c = top_byte(c, b, md);
		end
		return c;
	endfunction

	function automatic ctx_t feed(ctx_t ci, logic [7:0] b, logic [15:0] md);
		ctx_t c;
		c = ci;
		unique case (c.s.mode) inside
			MODE_TOP: begin
				c = top_byte(c, b, md);
			end
			MODE_ZERO: begin
				if ((b == CH_LX) || (b == CH_UX)) begin
					c = emit(c, CH_ZERO, 1'b0);
					c = emit(c, b, 1'b0);
					c = start_run(c);
				end else if (c.s.zwf) begin
					c = start_run(c);
					c = run_byte(c, CH_ZERO, 1'b0, md);
					c = in_run_byte(c, b, md);
				end else begin
					c = emit(c, CH_ZERO, 1'b0);
					c.s.mode = MODE_TOP;
					c = top_byte(c, b, md);
				end
			end
			MODE_RUN, MODE_RAW: begin
				c = in_run_byte(c, b, md);
			end
		endcase
		return c;
	endfunction

	function automatic ctx_t finish(ctx_t ci, logic [15:0] md);
		ctx_t c;
		c = ci;
		if (c.s.mode == MODE_ZERO) begin
			if (c.s.zwf) begin
				c = start_run(c);
				c = run_byte(c, CH_ZERO, 1'b0, md);
				c = close_run(c, md);
			end else begin
				c = emit(c, CH_ZERO, 1'b0);
			end
		end else begin
			c = close_run(c, md);
		end
		c.s.mode  = MODE_TOP;
		c.s.first = 1'b1;
		c.s.zwf   = 1'b0;
		c.s.len   = '0;
		c.s.digit = 1'b0;
		return c;
	endfunction

	always_comb begin
		nxt   = '0;
		nxt.s = scan_q;
		nxt   = feed(nxt, in_byte, min_digits_q);
		if (in_last) begin
			nxt = finish(nxt, min_digits_q);
		end
		// Bytes that would pass the per-item result limit are dropped.
		if (nxt.r.close == CLOSE_BUF) begin
			if (nxt.r.cnt >= CNT_W'(RESULT_CAP)) begin
				nxt.r.b0_v = 1'b0;
				nxt.r.b1_v = 1'b0;
			end else if (nxt.r.cnt >= CNT_W'(RESULT_CAP - 1)) begin
				nxt.r.b1_v = 1'b0;
			end
		end
		nxt.r.last = in_last;
	end

	// The buffer is not written while a flush that reads it is still pending.
	assign in_stall  = q_full || ((busy_q != '0) && nxt.we);
	assign accept    = in_valid && !in_stall;
	assign push      = accept && ((nxt.r.close != CLOSE_NONE) || nxt.r.b0_v);
	assign push_rec  = nxt.r;
	assign buf_inc   = push && (nxt.r.close == CLOSE_BUF);
	assign ram_we    = accept && nxt.we;
	assign ram_waddr = nxt.wa;
	assign ram_wdata = nxt.wd;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '{mode: MODE_TOP, first: 1'b1, zwf: 1'b0, len: '0, digit: 1'b0};
			min_digits_q <= '0;
			busy_q       <= '0;
		end else begin
			if (cfg_valid) begin
				min_digits_q <= min_digits;
			end
			if (accept) begin
				scan_q <= nxt.s;
			end
			busy_q <= busy_q + BW'(buf_inc) - BW'(buf_done);
		end
	end

endmodule

/* rtl/hrm_queue.sv */
module hrm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hrm_pkg::rec_t push_rec,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output hrm_pkg::rec_t head
);

	import hrm_pkg::*;

	localparam int PW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	rec_t          slot_q [Q_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_rec;
		end
	end

endmodule

/* rtl/hrm_back.sv */
module hrm_back #(
	parameter int MAX_RUN = hrm_pkg::DEF_MAX_RUN
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  hrm_pkg::rec_t              head,
	output logic                       pop,
	output logic                       ram_re,
	output logic [$clog2(MAX_RUN)-1:0] ram_raddr,
	input  logic [7:0]                 ram_rdata,
	output logic                       buf_done,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       out_last,
	output logic                       overflow
);

	import hrm_pkg::*;

	localparam int AW      = $clog2(MAX_RUN);
	localparam int NUM_LEN = 5;

	function automatic logic [7:0] num_char(logic [2:0] i);
		logic [7:0] ch;
		case (i)
			3'd0:    ch = "<";
			3'd1:    ch = "n";
			3'd2:    ch = "u";
			3'd3:    ch = "m";
			default: ch = ">";
		endcase
		return ch;
	endfunction

	logic [CNT_W-1:0] e_q;
	logic [CNT_W-1:0] n_close;
	logic [CNT_W-1:0] total;
	logic             in_close;
	logic             at_end;
	logic             issue;
	logic             load_s1;
	logic             ready_s2;
	logic [7:0]       el_lit;
	logic             el_ram;
	logic             el_ovf;

	logic             valid_s1;
	logic [7:0]       lit_s1;
	logic             ram_s1;
	logic             ovf_s1;
	logic             last_s1;
	logic             valid_s2;
	logic [7:0]       byte_s2;
	logic             last_s2;
	logic             ovf_s2;

	always_comb begin
		if (head.close == CLOSE_NUM) begin
			n_close = CNT_W'(NUM_LEN);
		end else if (head.close == CLOSE_BUF) begin
			n_close = head.cnt;
		end else begin
			n_close = '0;
		end
		total    = n_close + CNT_W'(head.b0_v) + CNT_W'(head.b1_v);
		in_close = (e_q < n_close);
		at_end   = (e_q == total - 1'b1);

		el_lit = head.b1;
		el_ram = 1'b0;
		el_ovf = head.b1_ovf;
		if (in_close) begin
			el_lit = num_char(e_q[2:0]);
			el_ram = (head.close == CLOSE_BUF);
			el_ovf = head.close_ovf;
		end else if (e_q == n_close) begin
			el_lit = head.b0;
			el_ovf = head.b0_ovf;
		end
	end

	assign ready_s2  = !valid_s2 || !out_stall;
	assign load_s1   = !valid_s1 || ready_s2;
	assign issue     = head_valid && load_s1;
	assign pop       = issue && at_end;
	assign ram_re    = issue && el_ram;
	assign ram_raddr = e_q[AW-1:0];
	assign buf_done  = issue && (head.close == CLOSE_BUF) && (e_q == n_close - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q      <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (issue) begin
				e_q <= at_end ? '0 : e_q + 1'b1;
			end
			if (load_s1) begin
				valid_s1 <= issue;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			lit_s1  <= el_lit;
			ram_s1  <= el_ram;
			ovf_s1  <= el_ovf;
			last_s1 <= head.last && at_end;
		end
		if (ready_s2) begin
			byte_s2 <= ram_s1 ? ram_rdata : lit_s1;
			last_s2 <= last_s1;
			ovf_s2  <= ovf_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_byte  = byte_s2;
	assign out_last  = last_s2;
	assign overflow  = ovf_s2;

endmodule
